>>> src/apt_pkg.sv
package apt_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int WORD_BITS  = 32;
    localparam int FIELD_BITS = 32;

    // Stored entries and point coordinates keep at most FIELD_BITS bits.
    localparam int STORE_BITS = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;
    localparam int SHIFT_BITS = 2 * STORE_BITS - FRAC_BITS;
    localparam int SUM_A      = (SHIFT_BITS > WORD_BITS) ? SHIFT_BITS : WORD_BITS;
    localparam int SUM_B      = (SUM_A > FIELD_BITS) ? SUM_A : FIELD_BITS;
    localparam int SUM_BITS   = SUM_B + 2;

    localparam int ROWS     = 3;
    localparam int COLS     = 4;
    localparam int LIN_COLS = 3;
    localparam int ENTRIES  = ROWS * COLS;
    localparam int IDX_BITS = $clog2(ENTRIES);

    localparam logic [1:0] ROW_NONE = 2'd3;

    localparam longint ONE_RAW   = 64'sd1 <<< FRAC_BITS;
    localparam longint STORE_TOP = (64'sd1 <<< (STORE_BITS - 1)) - 64'sd1;
    localparam longint ONE_VAL   = (ONE_RAW > STORE_TOP) ? STORE_TOP : ONE_RAW;
    localparam longint WORD_MAX  = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;

    typedef logic signed [STORE_BITS-1:0] t_word;
    typedef logic signed [SHIFT_BITS-1:0] t_prod;

    localparam t_word ONE_WORD = STORE_BITS'(ONE_VAL);

    typedef logic [ENTRIES-1:0][STORE_BITS-1:0]            t_matrix;
    typedef logic [ROWS-1:0][LIN_COLS-1:0][SHIFT_BITS-1:0] t_prods;
    typedef logic [ROWS-1:0][STORE_BITS-1:0]               t_trans;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_XFORM = 2'd1,
        CMD_IDENT = 2'd2
    } t_cmd;

    typedef struct packed {
        logic       wr;
        logic       ident;
        logic [1:0] row;
        logic [1:0] col;
        t_word      value;
    } t_mat_cmd;

    function automatic t_matrix identity_matrix();
        t_matrix m;
        m = '0;
        for (int r = 0; r < ROWS; r++) begin
            m[r * COLS + r] = ONE_WORD;
        end
        return m;
    endfunction

endpackage

>>> src/apt_matrix.sv
module apt_matrix
    import apt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mat_cmd i_cmd,
    output t_matrix  o_matrix
);

    t_matrix               r_m;
    t_matrix               n_m;
    logic [IDX_BITS-1:0]   w_idx;

    assign w_idx = IDX_BITS'(IDX_BITS'(i_cmd.row) * IDX_BITS'(COLS) + IDX_BITS'(i_cmd.col));

    always_comb begin
        n_m = r_m;
        if (i_cmd.ident) begin
            n_m = identity_matrix();
        end else if (i_cmd.wr && i_cmd.row != ROW_NONE) begin
            n_m[w_idx] = i_cmd.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m <= identity_matrix();
        end else begin
            r_m <= n_m;
        end
    end

    assign o_matrix = r_m;

`ifndef SYNTHESIS
    a_ident_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ident |=> r_m == identity_matrix())
        else $error("identity reload did not restore the matrix");

    a_row_none_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr && !i_cmd.ident && i_cmd.row == ROW_NONE) |=> $stable(r_m))
        else $error("write to an absent row changed the matrix");

    a_write_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr && !i_cmd.ident && i_cmd.row != ROW_NONE)
        |=> r_m[$past(w_idx)] == $past(i_cmd.value))
        else $error("matrix write did not land");
`endif

endmodule

>>> src/apt_product.sv
module apt_product
    import apt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  logic    i_adv,
    input  t_matrix i_matrix,
    input  t_word   i_x,
    input  t_word   i_y,
    input  t_word   i_z,
    output logic    o_valid,
    output t_prods  o_prod,
    output t_trans  o_trans
);

    logic                              r_valid;
    t_prods                            r_prod;
    t_trans                            r_trans;
    t_prods                            n_prod;
    t_trans                            n_trans;
    logic signed [2*STORE_BITS-1:0]    w_full [ROWS][LIN_COLS];
    t_word                             w_pt   [LIN_COLS];

    assign w_pt[0] = i_x;
    assign w_pt[1] = i_y;
    assign w_pt[2] = i_z;

    // Nine independent products; dropping the low fraction bits floors them.
    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            n_trans[r] = i_matrix[r * COLS + LIN_COLS];
            for (int c = 0; c < LIN_COLS; c++) begin
                w_full[r][c] = $signed(i_matrix[r * COLS + c]) * w_pt[c];
                n_prod[r][c] = w_full[r][c][2*STORE_BITS-1:FRAC_BITS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod  <= n_prod;
            r_trans <= n_trans;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;
    assign o_trans = r_trans;

endmodule

>>> src/apt_accum.sv
module apt_accum
    import apt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_prods                  i_prod,
    input  t_trans                  i_trans,
    input  logic                    i_stall,
    output logic                    o_valid,
    output logic signed [FIELD_BITS-1:0] o_x,
    output logic signed [FIELD_BITS-1:0] o_y,
    output logic signed [FIELD_BITS-1:0] o_z,
    output logic                    o_saturated
);

    localparam logic signed [SUM_BITS-1:0] SUM_HI = SUM_BITS'(WORD_MAX);
    localparam logic signed [SUM_BITS-1:0] SUM_LO = -SUM_HI - SUM_BITS'(1);

    logic                          r_valid;
    logic [ROWS-1:0][FIELD_BITS-1:0] r_res;
    logic                          r_sat;
    logic signed [SUM_BITS-1:0]    w_sum   [ROWS];
    logic signed [SUM_BITS-1:0]    w_clamp [ROWS];
    logic [ROWS-1:0]               w_hit;
    logic                          w_take;

    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            w_sum[r] = SUM_BITS'($signed(i_trans[r]))
                     + SUM_BITS'($signed(i_prod[r][0]))
                     + SUM_BITS'($signed(i_prod[r][1]))
                     + SUM_BITS'($signed(i_prod[r][2]));
            w_hit[r]   = 1'b1;
            w_clamp[r] = w_sum[r];
            if (w_sum[r] > SUM_HI) begin
                w_clamp[r] = SUM_HI;
            end else if (w_sum[r] < SUM_LO) begin
                w_clamp[r] = SUM_LO;
            end else begin
                w_hit[r] = 1'b0;
            end
        end
    end

    assign o_ready = !r_valid || !i_stall;
    assign w_take  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            for (int r = 0; r < ROWS; r++) begin
                r_res[r] <= w_clamp[r][FIELD_BITS-1:0];
            end
            r_sat <= |w_hit;
        end
    end

    assign o_valid     = r_valid;
    assign o_x         = r_res[0];
    assign o_y         = r_res[1];
    assign o_z         = r_res[2];
    assign o_saturated = r_sat;

endmodule

>>> src/affine_point_transform_top.sv
// Affine 3D point transform with a 3x4 signed Q16.16 matrix (identity after reset).
// Each item is a command: write one matrix entry, reload the identity, or transform
// a point; only a transform returns a result, x' = m00*x + m01*y + m02*z + m03 and
// likewise for y' and z', each product floored and each sum saturated to 32 bits,
// with o_saturated set when any sum clamps. One item is taken every cycle, with no
// bubbles between commands of any kind, unless o_stall holds a transform that finds
// no room downstream; a transform passes through the input register, a bank of nine
// parallel 32x32 multipliers into the product register, then the four-term add and
// clamp into the result register. Matrix writes take effect in item order, so a
// transform sees every write accepted before it.
module affine_point_transform_top
    import apt_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_command,
    input  logic [1:0]                   i_entry_row,
    input  logic [1:0]                   i_entry_col,
    input  logic signed [FIELD_BITS-1:0] i_entry_value,
    input  logic signed [FIELD_BITS-1:0] i_point_x,
    input  logic signed [FIELD_BITS-1:0] i_point_y,
    input  logic signed [FIELD_BITS-1:0] i_point_z,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [FIELD_BITS-1:0] o_out_x,
    output logic signed [FIELD_BITS-1:0] o_out_y,
    output logic signed [FIELD_BITS-1:0] o_out_z,
    output logic                         o_saturated
);

    logic       r_in_valid;
    t_cmd       r_cmd;
    logic [1:0] r_row;
    logic [1:0] r_col;
    t_word      r_value;
    t_word      r_px;
    t_word      r_py;
    t_word      r_pz;

    logic       w_accept;
    logic       w_is_xform;
    logic       w_prod_valid;
    logic       w_acc_ready;
    logic       w_prod_free;
    logic       w_s1_go;
    t_mat_cmd   w_mat_cmd;
    t_matrix    w_matrix;
    t_prods     w_prod;
    t_trans     w_trans;

    assign w_is_xform  = (r_cmd == CMD_XFORM);
    assign w_prod_free = !w_prod_valid || w_acc_ready;
    // Only a transform needs room downstream; other commands retire here.
    assign w_s1_go     = r_in_valid && (!w_is_xform || w_prod_free);
    assign o_stall     = r_in_valid && !w_s1_go;
    assign w_accept    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= t_cmd'(i_command);
            r_row   <= i_entry_row;
            r_col   <= i_entry_col;
            r_value <= i_entry_value[STORE_BITS-1:0];
            r_px    <= i_point_x[STORE_BITS-1:0];
            r_py    <= i_point_y[STORE_BITS-1:0];
            r_pz    <= i_point_z[STORE_BITS-1:0];
        end
    end

    always_comb begin
        w_mat_cmd       = '0;
        w_mat_cmd.row   = r_row;
        w_mat_cmd.col   = r_col;
        w_mat_cmd.value = r_value;
        case (r_cmd)
            CMD_WRITE: w_mat_cmd.wr    = w_s1_go;
            CMD_IDENT: w_mat_cmd.ident = w_s1_go;
            default:   ;
        endcase
    end

    apt_matrix u_matrix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_mat_cmd),
        .o_matrix (w_matrix)
    );

    apt_product u_product (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_s1_go && w_is_xform),
        .i_adv    (w_acc_ready),
        .i_matrix (w_matrix),
        .i_x      (r_px),
        .i_y      (r_py),
        .i_z      (r_pz),
        .o_valid  (w_prod_valid),
        .o_prod   (w_prod),
        .o_trans  (w_trans)
    );

    apt_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_prod_valid),
        .o_ready     (w_acc_ready),
        .i_prod      (w_prod),
        .i_trans     (w_trans),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_x         (o_out_x),
        .o_y         (o_out_y),
        .o_z         (o_out_z),
        .o_saturated (o_saturated)
    );

`ifndef SYNTHESIS
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid)
        else $error("input stalled with an empty input stage");

    a_no_result_for_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_is_xform && !w_prod_valid) |=> !w_prod_valid)
        else $error("non-transform command produced a product item");

    a_xform_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_go && w_is_xform) |=> w_prod_valid)
        else $error("transform left the input stage without a product item");
`endif

endmodule

>>> tb/apt_checker.sv
`timescale 1ns / 1ps

module apt_checker
    import apt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [1:0]            i_command,
    input  logic [1:0]            i_entry_row,
    input  logic [1:0]            i_entry_col,
    input  logic [FIELD_BITS-1:0] i_entry_value,
    input  logic [FIELD_BITS-1:0] i_point_x,
    input  logic [FIELD_BITS-1:0] i_point_y,
    input  logic [FIELD_BITS-1:0] i_point_z,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [FIELD_BITS-1:0] i_out_x,
    input  logic [FIELD_BITS-1:0] i_out_y,
    input  logic [FIELD_BITS-1:0] i_out_z,
    input  logic                  i_saturated,
    output int                    o_errors,
    output int                    o_pending
);

    typedef struct {
        logic [FIELD_BITS-1:0] x;
        logic [FIELD_BITS-1:0] y;
        logic [FIELD_BITS-1:0] z;
        logic                  sat;
    } point_result_t;

    longint        coeffs [ENTRIES];
    point_result_t expected_points [$];
    int            err_count;

    assign o_errors = err_count;

    initial begin
        err_count = 0;
        o_pending = 0;
    end

    function automatic longint to_word(logic [FIELD_BITS-1:0] raw);
        t_word w;
        w = raw[STORE_BITS-1:0];
        return longint'(w);
    endfunction

    task automatic load_unit_matrix();
        for (int i = 0; i < ENTRIES; i++) begin
            coeffs[i] = 0;
        end
        for (int r = 0; r < ROWS; r++) begin
            coeffs[r * COLS + r] = ONE_VAL;
        end
    endtask

    function automatic point_result_t transform_point(longint px, longint py, longint pz);
        point_result_t         res;
        longint                acc;
        longint                hi;
        longint                lo;
        longint                pt [LIN_COLS];
        logic [FIELD_BITS-1:0] coord [ROWS];
        res.sat = 1'b0;
        hi = WORD_MAX;
        lo = -WORD_MAX - 64'sd1;
        pt[0] = px;
        pt[1] = py;
        pt[2] = pz;
        for (int r = 0; r < ROWS; r++) begin
            acc = coeffs[r * COLS + LIN_COLS];
            // floor each product, then sum exactly before the clamp
            for (int c = 0; c < LIN_COLS; c++) begin
                acc += (coeffs[r * COLS + c] * pt[c]) >>> FRAC_BITS;
            end
            if (acc > hi) begin
                acc = hi;
                res.sat = 1'b1;
            end else if (acc < lo) begin
                acc = lo;
                res.sat = 1'b1;
            end
            coord[r] = acc[FIELD_BITS-1:0];
        end
        res.x = coord[0];
        res.y = coord[1];
        res.z = coord[2];
        return res;
    endfunction

    task automatic check_field(string name, logic [FIELD_BITS-1:0] want,
                               logic [FIELD_BITS-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        point_result_t want;
        if (!i_rst_n) begin
            load_unit_matrix();
            expected_points.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                case (i_command)
                    CMD_WRITE: begin
                        // drop writes to the missing fourth row
                        if (i_entry_row != ROW_NONE) begin
                            coeffs[i_entry_row * COLS + i_entry_col] = to_word(i_entry_value);
                        end
                    end
                    CMD_IDENT: load_unit_matrix();
                    CMD_XFORM: begin
                        expected_points.push_back(transform_point(to_word(i_point_x),
                                                                  to_word(i_point_y),
                                                                  to_word(i_point_z)));
                    end
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected point, expected none actual %h %h %h %b",
                             $time, i_out_x, i_out_y, i_out_z, i_saturated);
                    err_count++;
                end else begin
                    want = expected_points.pop_front();
                    check_field("out_x", want.x, i_out_x);
                    check_field("out_y", want.y, i_out_y);
                    check_field("out_z", want.z, i_out_z);
                    check_field("saturated", FIELD_BITS'(want.sat), FIELD_BITS'(i_saturated));
                end
            end
        end
        o_pending <= expected_points.size();
    end

endmodule

>>> tb/tb_affine_point_transform_top.sv
`timescale 1ns / 1ps

module tb_affine_point_transform_top;
    import apt_pkg::*;

    localparam logic [1:0] CMD_SPARE   = 2'd3;
    localparam logic [1:0] TRANS_COL   = 2'd3;
    localparam int         RAND_ITEMS  = 1100;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         TAIL_CYCLES = 20;

    localparam logic [FIELD_BITS-1:0] Q_ONE     = 32'h0001_0000;
    localparam logic [FIELD_BITS-1:0] Q_NEG_ONE = 32'hFFFF_0000;
    localparam logic [FIELD_BITS-1:0] W_MAX     = 32'h7FFF_FFFF;
    localparam logic [FIELD_BITS-1:0] W_MIN     = 32'h8000_0000;

    typedef struct {
        logic [1:0]            cmd;
        logic [1:0]            row;
        logic [1:0]            col;
        logic [FIELD_BITS-1:0] value;
        logic [FIELD_BITS-1:0] x;
        logic [FIELD_BITS-1:0] y;
        logic [FIELD_BITS-1:0] z;
    } cmd_item_t;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic [1:0]                   i_command;
    logic [1:0]                   i_entry_row;
    logic [1:0]                   i_entry_col;
    logic signed [FIELD_BITS-1:0] i_entry_value;
    logic signed [FIELD_BITS-1:0] i_point_x;
    logic signed [FIELD_BITS-1:0] i_point_y;
    logic signed [FIELD_BITS-1:0] i_point_z;
    logic                         o_valid;
    logic                         i_stall;
    logic signed [FIELD_BITS-1:0] o_out_x;
    logic signed [FIELD_BITS-1:0] o_out_y;
    logic signed [FIELD_BITS-1:0] o_out_z;
    logic                         o_saturated;

    int mismatches;
    int pending;
    int cycles;
    bit calm;

    affine_point_transform_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_entry_row   (i_entry_row),
        .i_entry_col   (i_entry_col),
        .i_entry_value (i_entry_value),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_out_z       (o_out_z),
        .o_saturated   (o_saturated)
    );

    apt_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_command     (i_command),
        .i_entry_row   (i_entry_row),
        .i_entry_col   (i_entry_col),
        .i_entry_value (i_entry_value),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_out_x       (o_out_x),
        .i_out_y       (o_out_y),
        .i_out_z       (o_out_z),
        .i_saturated   (o_saturated),
        .o_errors      (mismatches),
        .o_pending     (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_affine_point_transform_top: done, errors");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [FIELD_BITS-1:0] rand_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return int'($urandom_range(0, 524288)) - 262144;
            4, 5:       return int'($urandom_range(0, 33554432)) - 16777216;
            6, 7:       return $urandom;
            default: begin
                case ($urandom_range(0, 5))
                    0:       return W_MAX;
                    1:       return W_MIN;
                    2:       return Q_ONE;
                    3:       return Q_NEG_ONE;
                    4:       return '1;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    function automatic cmd_item_t make_item(logic [1:0] cmd, logic [1:0] row, logic [1:0] col,
                                            logic [FIELD_BITS-1:0] value,
                                            logic [FIELD_BITS-1:0] x,
                                            logic [FIELD_BITS-1:0] y,
                                            logic [FIELD_BITS-1:0] z);
        cmd_item_t it;
        it.cmd   = cmd;
        it.row   = row;
        it.col   = col;
        it.value = value;
        it.x     = x;
        it.y     = y;
        it.z     = z;
        return it;
    endfunction

    function automatic cmd_item_t random_item();
        cmd_item_t it;
        int        r;
        it = make_item(CMD_XFORM, $urandom_range(0, 2), $urandom_range(0, 3),
                       rand_word(), rand_word(), rand_word(), rand_word());
        r = $urandom_range(0, 99);
        if (r < 36) begin
            it.cmd = CMD_WRITE;
            if ($urandom_range(0, 19) == 0) it.row = ROW_NONE;
        end else if (r < 40) begin
            it.cmd = CMD_IDENT;
        end else if (r < 43) begin
            it.cmd = CMD_SPARE;
            it.row = $urandom_range(0, 3);
        end else begin
            it.row = $urandom_range(0, 3);
        end
        return it;
    endfunction

    // Hold the item until the block takes it.
    task automatic issue_item(input cmd_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= it.cmd;
        i_entry_row   <= it.row;
        i_entry_col   <= it.col;
        i_entry_value <= it.value;
        i_point_x     <= it.x;
        i_point_y     <= it.y;
        i_point_z     <= it.z;
        do @(posedge i_clk); while (o_stall);
    endtask

    initial begin
        int n;
        int run;
        i_stall = 1'b0;
        repeat (4) @(posedge i_clk);
        forever begin
            n   = pick_gap();
            run = $urandom_range(1, 12);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat (run) @(posedge i_clk);
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_command     = CMD_WRITE;
        i_entry_row   = '0;
        i_entry_col   = '0;
        i_entry_value = '0;
        i_point_x     = '0;
        i_point_y     = '0;
        i_point_z     = '0;
        calm          = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identity after reset
        issue_item(make_item(CMD_XFORM, 0, 0, 0, Q_ONE, 32'h0002_0000, 32'hFFFD_0000));
        issue_item(make_item(CMD_XFORM, 0, 0, 0, W_MAX, W_MIN, 0));
        // translation at the limits, clamp high and low
        issue_item(make_item(CMD_WRITE, 0, TRANS_COL, W_MAX, 0, 0, 0));
        issue_item(make_item(CMD_XFORM, 0, 0, 0, Q_ONE, 0, 0));
        issue_item(make_item(CMD_WRITE, 1, TRANS_COL, W_MIN, 0, 0, 0));
        issue_item(make_item(CMD_XFORM, 0, 0, 0, 0, Q_NEG_ONE, 0));
        issue_item(make_item(CMD_IDENT, 0, 0, 0, 0, 0, 0));
        // overflowing products
        issue_item(make_item(CMD_WRITE, 0, 0, W_MAX, 0, 0, 0));
        issue_item(make_item(CMD_XFORM, 0, 0, 0, W_MAX, 0, 0));
        issue_item(make_item(CMD_WRITE, 0, 0, W_MIN, 0, 0, 0));
        issue_item(make_item(CMD_XFORM, 0, 0, 0, W_MIN, 0, 0));
        issue_item(make_item(CMD_XFORM, 0, 0, 0, W_MAX, 0, 0));
        // truncation of a tiny product rounds toward minus infinity
        issue_item(make_item(CMD_WRITE, 0, 0, 32'h0000_0001, 0, 0, 0));
        issue_item(make_item(CMD_XFORM, 0, 0, 0, '1, 0, 0));
        issue_item(make_item(CMD_XFORM, 0, 0, 0, 32'h0000_0001, 0, 0));
        // write to the missing row and the unused command change nothing
        issue_item(make_item(CMD_WRITE, ROW_NONE, 0, 32'h1234_5678, 0, 0, 0));
        issue_item(make_item(CMD_XFORM, 0, 0, 0, Q_ONE, Q_ONE, Q_ONE));
        issue_item(make_item(CMD_SPARE, 1, 2, 32'hDEAD_BEEF, W_MAX, W_MIN, Q_ONE));
        issue_item(make_item(CMD_XFORM, 0, 0, 0, Q_ONE, Q_ONE, Q_ONE));
        issue_item(make_item(CMD_WRITE, 2, 1, 32'hFFFE_0000, 0, 0, 0));
        issue_item(make_item(CMD_WRITE, 1, 2, 32'h0000_8000, 0, 0, 0));
        issue_item(make_item(CMD_XFORM, 0, 0, 0, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000));
        issue_item(make_item(CMD_IDENT, 0, 0, 0, 0, 0, 0));
        issue_item(make_item(CMD_XFORM, 0, 0, 0, $urandom, $urandom, $urandom));

        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i % 150 == 0) calm = ($urandom_range(0, 3) == 0);
            issue_item(random_item());
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_affine_point_transform_top: done, clean");
        end else begin
            $display("tb_affine_point_transform_top: done, errors");
        end
        $finish;
    end

endmodule
